// ===== sv/fault_injection_sequencer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fault injection sequencer
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FAULT_INJECTION_SEQUENCER_TOP_MACROS_SVH
`define FAULT_INJECTION_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication.
`define FIS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fault injection sequencer: same-cycle check failed");

// Next-cycle implication.
`define FIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fault injection sequencer: next-cycle check failed");

`endif

// ===== sv/fis_pkg.sv =====
// ----------------------------------------------------------------------------
// Fault injection sequencer package
// Word types, codes and sizing constants shared by the cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package fis_pkg;

  localparam int NUM_FAULT_IDS = 32;
  localparam int NUM_BITS      = (NUM_FAULT_IDS < 32) ? NUM_FAULT_IDS : 32;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_TIMED   = 2'd1;
  localparam logic [1:0] MODE_WALK    = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  localparam logic [1:0] OUTCOME_OK     = 2'd0;
  localparam logic [1:0] OUTCOME_BAD_MODE = 2'd1;
  localparam logic [1:0] OUTCOME_BAD_ID = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic        enable;
    logic [1:0]  mode;
    logic [7:0]  fault_id;
    logic [15:0] steps;
  } fis_in_t;

  typedef struct packed {
    logic [31:0] fault_bits;
    logic [1:0]  mode_now;
    logic        active;
    logic [1:0]  outcome;
  } fis_out_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic        clear;
    logic        tick_timed;
    logic        walk_adv;
    logic [15:0] arm_count;
  } fis_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/fis_cell.sv =====
// ----------------------------------------------------------------------------
// Fault injection cell
// Holds one fault id's countdown and armed flag and one slot of the walk token.
// ----------------------------------------------------------------------------
`default_nettype none

module fis_cell
  import fis_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire fis_ctrl_t ctrl,
  input  wire logic      arm_sel,
  input  wire logic      tok_seed,
  input  wire logic      tok_in,
  output logic           armed,
  output logic           token
);

  logic [15:0] count_r, count_nxt;
  logic        armed_r, armed_nxt;
  logic        token_r, token_nxt;

  always_comb begin
    count_nxt = count_r;
    armed_nxt = armed_r;
    token_nxt = token_r;
    if (ctrl.clear) begin
      armed_nxt = 1'b0;
      token_nxt = tok_seed;
    end
    if (ctrl.tick_timed && armed_r) begin
      count_nxt = count_r - 16'd1;
      armed_nxt = (count_r != 16'd1);
    end
    if (ctrl.walk_adv) begin
      token_nxt = tok_in;
    end
    // Arming wins over a clear so that a new timed run can start in one word.
    if (arm_sel) begin
      count_nxt = ctrl.arm_count;
      armed_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    if (!rst_n) begin
      armed_r <= 1'b0;
      token_r <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
      token_r <= token_nxt;
    end
  end

  assign armed = armed_r;
  assign token = token_r;

endmodule

`default_nettype wire

// ===== sv/fault_injection_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Fault injection sequencer, top level
// Timed and walking fault runs over a row of per-id countdown cells.
// ----------------------------------------------------------------------------
//
//   channel   ports                       handshake
//   -------   -------------------------   ---------------------------------
//   input     start, busy, in_word        taken when start is high, busy low
//   result    out_strobe, out_word        one-cycle strobe, cannot be held
//
// Every input word is taken in the cycle it is offered; busy stays low, so
// a new word may follow in every cycle. Its result word appears on the
// cycle after acceptance, marked by out_strobe for exactly one cycle. The
// whole update needs no iteration because each fault id has its own countdown
// cell and the walk token moves one cell per advance. Reset is synchronous,
// active low, and leaves every cell disarmed and the sequencer idle. There
// is no stall on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fault_injection_sequencer_top_macros.svh"

module fault_injection_sequencer_top
  import fis_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire fis_in_t in_word,
  output logic         out_strobe,
  output fis_out_t     out_word
);

  // The sequencer never needs to refuse a word.
  assign busy = 1'b0;

  logic        accept;
  assign accept = start && !busy;

  // Run state.
  logic [1:0]  mode_r, mode_nxt;
  logic        active_r, active_nxt;
  logic [15:0] walk_left_r, walk_left_nxt;
  logic [15:0] walk_reload_r, walk_reload_nxt;

  // Result register.
  logic        strobe_r;
  fis_out_t    out_r, out_nxt;

  // Cell row interface.
  fis_ctrl_t                  ctrl;
  logic                       arm;
  logic                       walk_start;
  logic [NUM_FAULT_IDS-1:0]   arm_sel;
  logic [NUM_FAULT_IDS-1:0]   armed_vec;
  logic [NUM_FAULT_IDS-1:0]   token_vec;

  logic [15:0] eff_steps;
  logic        id_ok;
  logic        any_armed;
  logic        walk_last;
  logic [31:0] bits;

  assign eff_steps = (in_word.steps == 16'd0) ? 16'd1 : in_word.steps;
  assign id_ok     = ({24'd0, in_word.fault_id} < 32'(NUM_FAULT_IDS));
  assign any_armed = |armed_vec;
  assign walk_last = token_vec[NUM_FAULT_IDS-1];

  // The decision logic: one word in, next state of the run and the
  // broadcast commands to the cells out.
  always_comb begin
    mode_nxt        = mode_r;
    active_nxt      = active_r;
    walk_left_nxt   = walk_left_r;
    walk_reload_nxt = walk_reload_r;
    ctrl.clear      = 1'b0;
    ctrl.tick_timed = 1'b0;
    ctrl.walk_adv   = 1'b0;
    ctrl.arm_count  = eff_steps;
    arm             = 1'b0;
    walk_start      = 1'b0;
    bits            = 32'd0;
    out_nxt.outcome = OUTCOME_OK;

    if (accept) begin
      if (in_word.cmd) begin
        if (!in_word.enable) begin
          ctrl.clear      = 1'b1;
          mode_nxt        = MODE_IDLE;
          active_nxt      = 1'b0;
          walk_left_nxt   = 16'd0;
          walk_reload_nxt = 16'd0;
        end else if (in_word.mode == MODE_WALK) begin
          // A walk restarts from id 0: the clear seeds the token there.
          ctrl.clear      = 1'b1;
          walk_start      = 1'b1;
          mode_nxt        = MODE_WALK;
          active_nxt      = 1'b1;
          walk_left_nxt   = eff_steps;
          walk_reload_nxt = eff_steps;
        end else if (in_word.mode == MODE_TIMED) begin
          if (!id_ok) begin
            out_nxt.outcome = OUTCOME_BAD_ID;
          end
          if (active_r && mode_r == MODE_TIMED) begin
            // Adding a fault to a running timed run.
            arm = id_ok;
          end else begin
            // Starting a timed run; a bad id leaves the block stopped.
            ctrl.clear      = 1'b1;
            arm             = id_ok;
            walk_left_nxt   = 16'd0;
            walk_reload_nxt = 16'd0;
            mode_nxt        = id_ok ? MODE_TIMED : MODE_IDLE;
            active_nxt      = id_ok;
          end
        end else begin
          out_nxt.outcome = OUTCOME_BAD_MODE;
        end
      end else if (active_r) begin
        if (mode_r == MODE_TIMED) begin
          bits = 32'(armed_vec[NUM_BITS-1:0]);
          if (any_armed) begin
            ctrl.tick_timed = 1'b1;
          end else begin
            ctrl.clear      = 1'b1;
            mode_nxt        = MODE_IDLE;
            active_nxt      = 1'b0;
            walk_left_nxt   = 16'd0;
            walk_reload_nxt = 16'd0;
          end
        end else if (mode_r == MODE_WALK) begin
          bits          = 32'(token_vec[NUM_BITS-1:0]);
          walk_left_nxt = walk_left_r - 16'd1;
          if (walk_left_r == 16'd1) begin
            // Advancing past the last id empties the token row.
            ctrl.walk_adv = 1'b1;
            if (walk_last) begin
              active_nxt = 1'b0;
              mode_nxt   = MODE_IDLE;
            end else begin
              walk_left_nxt = walk_reload_r;
            end
          end
        end else if (mode_r != MODE_IDLE) begin
          active_nxt = 1'b0;
          mode_nxt   = MODE_IDLE;
        end
      end
    end

    out_nxt.fault_bits = bits;
    out_nxt.mode_now   = mode_nxt;
    out_nxt.active     = active_nxt;
  end

  // The cell row. The walk token travels from each cell to its neighbor.
  for (genvar i = 0; i < NUM_FAULT_IDS; i++) begin : g_cell
    logic tok_in;
    logic tok_seed;
    if (i == 0) begin : g_head
      assign tok_in   = 1'b0;
      assign tok_seed = walk_start;
    end else begin : g_body
      assign tok_in   = token_vec[i-1];
      assign tok_seed = 1'b0;
    end

    assign arm_sel[i] = arm && (in_word.fault_id == 8'(i));

    fis_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .arm_sel  (arm_sel[i]),
      .tok_seed (tok_seed),
      .tok_in   (tok_in),
      .armed    (armed_vec[i]),
      .token    (token_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      active_r      <= 1'b0;
      walk_left_r   <= 16'd0;
      walk_reload_r <= 16'd0;
      strobe_r      <= 1'b0;
    end else begin
      mode_r        <= mode_nxt;
      active_r      <= active_nxt;
      walk_left_r   <= walk_left_nxt;
      walk_reload_r <= walk_reload_nxt;
      strobe_r      <= accept;
    end
  end

  assign out_strobe = strobe_r;
  assign out_word   = out_r;

  // Every accepted word gets exactly one result on the next cycle.
  `FIS_ASSERT_NEXT(a_result_follows, accept, out_strobe)
  `FIS_ASSERT_NEXT(a_no_spurious_result, !accept, !out_strobe)
  // A running walk has exactly one id selected.
  `FIS_ASSERT_IMPL(a_walk_token, active_r && mode_r == MODE_WALK, $onehot(token_vec))
  // Once stopped, no cell is left armed or holding the token.
  `FIS_ASSERT_IMPL(a_idle_clean, !active_r, armed_vec == '0 && token_vec == '0)
  // A rejected command never raises fault bits.
  `FIS_ASSERT_IMPL(a_reject_quiet, out_strobe && out_word.outcome != OUTCOME_OK,
                   out_word.fault_bits == 32'd0)

endmodule

`default_nettype wire
